FILE: hw/rtl/sss_pkg.sv
package sss_pkg;

  localparam int unsigned CharW        = 21;
  localparam int unsigned DefaultDepth = 10;
  localparam int unsigned CmdDepth     = 4;

  localparam logic [1:0] ModeHan    = 2'd0;
  localparam logic [1:0] ModeTibRom = 2'd1;
  localparam logic [1:0] ModeTibScr = 2'd2;
  localparam logic [1:0] ModeSkt    = 2'd3;

  localparam logic [CharW-1:0] Tsheg     = 21'h00F0B;
  localparam logic [CharW-1:0] TshegAlt  = 21'h00F0C;
  localparam logic [CharW-1:0] Shad      = 21'h00F0D;
  localparam logic [CharW-1:0] ShadAlt   = 21'h00F11;
  localparam logic [CharW-1:0] SktRVowel = 21'h01E5B;
  localparam logic [CharW-1:0] SktAnusM  = 21'h01E41;
  localparam logic [CharW-1:0] SktAnusN  = 21'h01E43;
  localparam logic [CharW-1:0] SktVisarg = 21'h01E25;
  localparam logic [CharW-1:0] LetterA   = 21'h00061;
  localparam logic [CharW-1:0] LetterI   = 21'h00069;
  localparam logic [CharW-1:0] LetterU   = 21'h00075;

  typedef enum logic [2:0] {
    CL_START = 3'd0,
    CL_PLAIN = 3'd1,
    CL_CONS  = 3'd2,
    CL_FINAL = 3'd3,
    CL_SHAD  = 3'd4,
    CL_SPEC  = 3'd5
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND,
    ST_STORE
  } back_state_e;

  // One command per accepted transaction that touches the store.
  typedef struct packed {
    logic             pre_emit;
    logic             pre_clear;
    logic             hold;
    logic             post_emit;
    logic [CharW-1:0] ch;
  } cmd_t;

  localparam int unsigned NumHan = 44;
  localparam logic [CharW-1:0] HanMarks [NumHan] = '{
    21'h20, 21'h3002, 21'h2E, 21'h0A, 21'h2D, 21'h2C, 21'h2F, 21'h28, 21'h29,
    21'h5C, 21'h2551, 21'h3D, 21'h3A, 21'h23, 21'h5F, 21'h0D, 21'h3010,
    21'h3011, 21'h300B, 21'hFF0C, 21'h3000, 21'h3001, 21'hFF1A, 21'h300C,
    21'h300D, 21'hFF1F, 21'hFF01, 21'hFF1B, 21'h300E, 21'h300F, 21'hFF09,
    21'hFF08, 21'hFF0E, 21'h2026, 21'h25CB, 21'h5D, 21'h5B, 21'h2A, 21'h300A,
    21'h2B, 21'hFF0F, 21'h3009, 21'h3008, 21'h25C7
  };

  localparam int unsigned NumTib = 20;
  localparam logic [CharW-1:0] TibMarks [NumTib] = '{
    21'h20, 21'h2E, 21'h0A, 21'h2D, 21'h2C, 21'h2F, 21'h28, 21'h29, 21'h5C,
    21'h2551, 21'h3D, 21'h3A, 21'h23, 21'h5F, 21'h0D, 21'h3010, 21'h3011,
    21'h5B, 21'h5D, 21'h300B
  };

  localparam int unsigned NumCons = 23;
  localparam logic [CharW-1:0] SktCons [NumCons] = '{
    21'h6B, 21'h68, 21'h67, 21'h1E45, 21'h63, 21'h6A, 21'hF1, 21'h1E6D,
    21'h1E0D, 21'h1E47, 21'h74, 21'h64, 21'h6E, 21'h70, 21'h62, 21'h6D,
    21'h79, 21'h72, 21'h6C, 21'h76, 21'h15B, 21'h1E63, 21'h73
  };

  localparam int unsigned NumVow = 12;
  localparam logic [CharW-1:0] SktVow [NumVow] = '{
    21'h61, 21'h69, 21'h75, 21'h65, 21'h6F, 21'h101, 21'h12B, 21'h16B,
    21'h1E5B, 21'h1E5D, 21'h1E37, 21'h1E39
  };

  function automatic logic in_han(logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumHan; i++) hit |= (HanMarks[i] == c);
    return hit;
  endfunction

  function automatic logic in_tib(logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumTib; i++) hit |= (TibMarks[i] == c);
    return hit;
  endfunction

  function automatic logic in_cons(logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumCons; i++) hit |= (SktCons[i] == c);
    return hit;
  endfunction

  function automatic logic in_vow(logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumVow; i++) hit |= (SktVow[i] == c);
    return hit;
  endfunction

  function automatic logic is_upper(logic [CharW-1:0] c);
    return (c >= 21'h41) && (c <= 21'h5A);
  endfunction

  function automatic logic is_lower(logic [CharW-1:0] c);
    return (c >= 21'h61) && (c <= 21'h7A);
  endfunction

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= 21'h30) && (c <= 21'h39);
  endfunction

  // ASCII letters and digits except lowercase k
  function automatic logic latin_mark(logic [CharW-1:0] c);
    return is_upper(c) || is_digit(c) || (is_lower(c) && (c != 21'h6B));
  endfunction

  function automatic logic is_vowel_letter(logic [CharW-1:0] c);
    return (c == 21'h41) || (c == 21'h45) || (c == 21'h49) || (c == 21'h4F) ||
           (c == 21'h55) || (c == 21'h61) || (c == 21'h65) || (c == 21'h69) ||
           (c == 21'h6F) || (c == 21'h75);
  endfunction

  function automatic class_e classify(logic [CharW-1:0] c, logic [1:0] mode);
    class_e t;
    t = CL_SPEC;
    unique case (mode)
      ModeHan: begin
        t = (in_han(c) || latin_mark(c)) ? CL_SPEC : CL_PLAIN;
      end
      ModeTibRom: begin
        if (is_vowel_letter(c) || (c == 21'h27)) t = CL_PLAIN;
        else if (is_upper(c) || is_lower(c)) t = CL_CONS;
        else t = CL_SPEC;
      end
      ModeTibScr: begin
        if ((c == Tsheg) || (c == TshegAlt)) t = CL_FINAL;
        else if ((c == Shad) || (c == ShadAlt)) t = CL_SHAD;
        else if (in_tib(c) || latin_mark(c)) t = CL_SPEC;
        else t = CL_PLAIN;
      end
      default: begin
        if (in_cons(c)) t = CL_CONS;
        else if (in_vow(c)) t = CL_PLAIN;
        else if ((c == SktAnusM) || (c == SktAnusN) || (c == SktVisarg)) t = CL_FINAL;
        else if (is_digit(c)) t = CL_SHAD;
        else t = CL_SPEC;
      end
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/sss_front.sv
module sss_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [sss_pkg::CharW-1:0] code_point_i,
  input  logic                     end_of_text_i,
  input  logic [1:0]               mode_i,
  output logic                     cmd_valid_o,
  output sss_pkg::cmd_t            cmd_o
);
  import sss_pkg::*;

  class_e           prev_class_q, prev_class_d;
  logic [CharW-1:0] prev_char_q, prev_char_d;
  class_e           t;
  cmd_t             cmd;

  assign t = classify(code_point_i, mode_i);

  always_comb begin
    cmd          = '0;
    cmd.ch       = code_point_i;
    prev_class_d = prev_class_q;
    prev_char_d  = prev_char_q;
    if (end_of_text_i) begin
      cmd.pre_emit = 1'b1;
      prev_class_d = CL_START;
      prev_char_d  = '0;
    end else if (prev_class_q == CL_START) begin
      cmd.pre_clear = 1'b1;
      cmd.hold      = 1'b1;
      unique case (mode_i)
        ModeHan:    prev_class_d = t;
        ModeTibRom: if (t != CL_SPEC) prev_class_d = t;
        ModeTibScr: if (t == CL_PLAIN) prev_class_d = t;
        default:    if (t == CL_CONS || t == CL_PLAIN) prev_class_d = t;
      endcase
    end else begin
      unique case (mode_i)
        ModeHan: begin
          if (t == CL_PLAIN) begin
            cmd.pre_emit = 1'b1;
            cmd.hold     = 1'b1;
          end
          prev_class_d = t;
          prev_char_d  = code_point_i;
        end
        ModeTibRom: begin
          if (prev_class_q != CL_SPEC && t == CL_SPEC) begin
            cmd.pre_emit = 1'b1;
            prev_class_d = t;
            prev_char_d  = code_point_i;
          end else if (t != CL_SPEC) begin
            cmd.hold     = 1'b1;
            prev_class_d = t;
            prev_char_d  = code_point_i;
          end
        end
        ModeTibScr: begin
          if (t == CL_FINAL) begin
            cmd.hold      = 1'b1;
            cmd.post_emit = 1'b1;
            prev_class_d  = t;
            prev_char_d   = code_point_i;
          end else if (prev_class_q == CL_PLAIN && t == CL_SHAD) begin
            // shad closes the syllable as a tsheg
            cmd.hold      = 1'b1;
            cmd.post_emit = 1'b1;
            cmd.ch        = Tsheg;
            prev_class_d  = t;
            prev_char_d   = code_point_i;
          end else if (t == CL_PLAIN) begin
            cmd.hold     = 1'b1;
            prev_class_d = t;
            prev_char_d  = code_point_i;
          end
        end
        default: begin
          if (t == CL_FINAL) begin
            cmd.hold      = 1'b1;
            cmd.post_emit = 1'b1;
            prev_class_d  = t;
            prev_char_d   = code_point_i;
          end else if (prev_class_q == CL_PLAIN &&
                       (t == CL_CONS || t == CL_PLAIN || t == CL_SHAD)) begin
            if (prev_char_q == LetterA &&
                (code_point_i == LetterI || code_point_i == LetterU)) begin
              // a+i / a+u diphthong stays in one syllable
              cmd.hold     = 1'b1;
              prev_class_d = t;
              prev_char_d  = code_point_i;
            end else if (code_point_i == LetterA || code_point_i == SktRVowel ||
                         t == CL_PLAIN || t == CL_CONS) begin
              cmd.pre_emit = 1'b1;
              cmd.hold     = 1'b1;
              prev_class_d = t;
              prev_char_d  = code_point_i;
            end
          end else if (t == CL_PLAIN || t == CL_CONS) begin
            cmd.hold     = 1'b1;
            prev_class_d = t;
            prev_char_d  = code_point_i;
          end
        end
      endcase
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = valid_i &&
                       (cmd.pre_emit || cmd.pre_clear || cmd.hold || cmd.post_emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_class_q <= CL_START;
      prev_char_q  <= '0;
    end else if (valid_i) begin
      prev_class_q <= prev_class_d;
      prev_char_q  <= prev_char_d;
    end
  end

endmodule

FILE: hw/rtl/sss_cmd_fifo.sv
module sss_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  sss_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output sss_pkg::cmd_t rdata_o
);
  import sss_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == PtrW'(CmdDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (do_rd) rptr_q <= (rptr_q == PtrW'(CmdDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: hw/rtl/sss_back.sv
module sss_back #(
  parameter int unsigned SyllableDepth = sss_pkg::DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_empty_i,
  input  sss_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [sss_pkg::CharW-1:0] out_char_o,
  output logic                      last_o,
  output logic                      trunc_o
);
  import sss_pkg::*;

  localparam int unsigned IdxW = $clog2(SyllableDepth);
  localparam int unsigned LenW = $clog2(SyllableDepth + 1);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [CharW-1:0] store_q [SyllableDepth];
  logic [LenW-1:0]  len_q;
  logic [IdxW-1:0]  idx_q;
  logic             ovf_q, post_q, post_d;
  logic             take, room;

  assign take   = pop_i && (state_q == ST_SEND);
  assign last_o = ((LenW'(idx_q) + LenW'(1)) == len_q);
  assign room   = (len_q < LenW'(SyllableDepth));

  always_comb begin
    state_d = state_q;
    post_d  = post_q;
    unique case (state_q)
      ST_IDLE:  if (!cmd_empty_i) state_d = ST_LOAD;
      ST_LOAD: begin
        if (cmd_q.pre_emit && len_q != '0) begin
          state_d = ST_SEND;
          post_d  = 1'b0;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_SEND:  if (take && last_o) state_d = post_q ? ST_IDLE : ST_STORE;
      ST_STORE: begin
        if (cmd_q.post_emit) begin
          state_d = ST_SEND;
          post_d  = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
    empty_o    = (state_q != ST_SEND);
    out_char_o = store_q[idx_q];
    trunc_o    = ovf_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (state_q == ST_STORE && cmd_q.hold && room) store_q[len_q[IdxW-1:0]] <= cmd_q.ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      post_q  <= 1'b0;
      len_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      post_q  <= post_d;
      unique case (state_q)
        ST_LOAD: begin
          // a held syllable about to be sent is kept until its last character
          if (cmd_q.pre_clear || (cmd_q.pre_emit && len_q == '0)) begin
            len_q <= '0;
            ovf_q <= 1'b0;
          end
          idx_q <= '0;
        end
        ST_SEND: begin
          if (take) begin
            if (last_o) begin
              idx_q <= '0;
              len_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        ST_STORE: begin
          if (cmd_q.hold) begin
            if (room) len_q <= len_q + LenW'(1);
            else ovf_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/script_syllable_segmenter.sv
// Script syllable segmenter.
// Input channel (push/full): one Unicode code point per transaction, or an
// end_of_text_i transaction that flushes the held syllable and restarts.
// Output channel (empty/pop): a finished syllable leaves one character per
// transaction, syllable_last_o on its final character, syllable_truncated_o
// on every character when characters past SYLLABLE_DEPTH were dropped.
// language_mode_i is written at cfg_we_i; write it only while idle.
// The front classifies a character in the cycle it is accepted and queues a
// store command in a 4-entry command queue; full stays low until it fills.
// The back finishes one command before it takes the next: idle, load, a send
// of the held syllable if the command emits before storing, store, and a send
// if it emits after; each send gives one character per pop from the back's
// single store port. With the back idle, the first result of a syllable shows
// once the command leaves load, or store when the closing character is part of it.
// When the receiver holds off pop, the back waits on the current character
// and the queue absorbs up to 4 commands before full rises.
// Reset empties the queue and store, sets start-of-text state and mode 0.
module script_syllable_segmenter #(
  parameter int unsigned SYLLABLE_DEPTH = sss_pkg::DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [sss_pkg::CharW-1:0] code_point_i,
  input  logic                      end_of_text_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [sss_pkg::CharW-1:0] out_char_o,
  output logic                      syllable_last_o,
  output logic                      syllable_truncated_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                language_mode_i
);
  import sss_pkg::*;

  logic [1:0] mode_q;
  logic       accept;
  logic       cmd_valid, cmd_empty, cmd_pop;
  cmd_t       cmd_in, cmd_out;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeHan;
    end else if (cfg_we_i) begin
      mode_q <= language_mode_i;
    end
  end

  assign accept = push && !full;

  // Front: classify and track previous class and character
  sss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .code_point_i  (code_point_i),
    .end_of_text_i (end_of_text_i),
    .mode_i        (mode_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd_in)
  );

  // Command queue decouples the front from the back
  sss_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd_in),
    .full_o  (full),
    .rd_i    (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_out)
  );

  // Back: syllable store and character stream
  sss_back #(
    .SyllableDepth (SYLLABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_char_o  (out_char_o),
    .last_o      (syllable_last_o),
    .trunc_o     (syllable_truncated_o)
  );

`ifndef SYNTHESIS
  // A syllable streams without gaps until its last character.
  a_stream_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !syllable_last_o |=> !empty)
    else $error("syllable stream broke before last character");

  // Truncation flag is constant across one syllable.
  a_trunc_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !syllable_last_o |=>
      syllable_truncated_o == $past(syllable_truncated_o))
    else $error("truncation flag changed within a syllable");
`endif

endmodule

FILE: dv/script_syllable_segmenter_tb.sv
module script_syllable_segmenter_tb;
  import sss_pkg::*;

  localparam int unsigned Depth     = DefaultDepth;
  // Back works through each stored character in turn; give it room before a cfg write.
  localparam int unsigned SettleCyc = 40;
  localparam int unsigned CycLimit  = 400000;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    logic             trunc;
  } syl_char_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [CharW-1:0] code_point_i = '0;
  logic             end_of_text_i = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [CharW-1:0] out_char_o;
  logic             syllable_last_o;
  logic             syllable_truncated_o;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       language_mode_i = ModeHan;

  script_syllable_segmenter #(.SYLLABLE_DEPTH(Depth)) dut (
    .clk_i, .rst_ni, .push, .full, .code_point_i, .end_of_text_i,
    .empty, .pop, .out_char_o, .syllable_last_o, .syllable_truncated_o,
    .cfg_we_i, .language_mode_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: held syllable, class/char of last used character, mode.
  logic [CharW-1:0] held_q [Depth];
  int unsigned      held_len;
  class_e           prev_cls;
  logic [CharW-1:0] prev_ch;
  logic             dropped;
  logic [1:0]       cur_mode;

  syl_char_t   pending_chars [$];
  int unsigned n_items, n_chars, n_syllables, n_trunc, n_eot, n_cfg;
  int unsigned errors, mismatches, cycles;
  int unsigned burst_left;
  int unsigned hold_off_cycles;
  int unsigned pop_pattern, pattern_left;

  // ---------------------------------------------------------------------
  // Own classification, using the package's character tables
  // ---------------------------------------------------------------------
  function automatic logic ascii_alnum(logic [CharW-1:0] c);
    return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h30 && c <= 21'h39) ||
           (c >= 21'h61 && c <= 21'h7A && c != 21'h6B);
  endfunction

  function automatic class_e char_class(logic [CharW-1:0] c, logic [1:0] mode);
    logic hit;
    logic letter;
    logic vowel;
    hit = 1'b0;
    letter = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    vowel = (c == 21'h41) || (c == 21'h45) || (c == 21'h49) || (c == 21'h4F) ||
            (c == 21'h55) || (c == 21'h61) || (c == 21'h65) || (c == 21'h69) ||
            (c == 21'h6F) || (c == 21'h75);
    case (mode)
      ModeHan: begin
        for (int i = 0; i < NumHan; i++) if (HanMarks[i] == c) hit = 1'b1;
        return (hit || ascii_alnum(c)) ? CL_SPEC : CL_PLAIN;
      end
      ModeTibRom: begin
        if (vowel || c == 21'h27) return CL_PLAIN;
        return letter ? CL_CONS : CL_SPEC;
      end
      ModeTibScr: begin
        if (c == Tsheg || c == TshegAlt) return CL_FINAL;
        if (c == Shad || c == ShadAlt) return CL_SHAD;
        for (int i = 0; i < NumTib; i++) if (TibMarks[i] == c) hit = 1'b1;
        return (hit || ascii_alnum(c)) ? CL_SPEC : CL_PLAIN;
      end
      default: begin
        for (int i = 0; i < NumCons; i++) if (SktCons[i] == c) return CL_CONS;
        for (int i = 0; i < NumVow; i++) if (SktVow[i] == c) return CL_PLAIN;
        if (c == SktAnusM || c == SktAnusN || c == SktVisarg) return CL_FINAL;
        if (c >= 21'h30 && c <= 21'h39) return CL_SHAD;
        return CL_SPEC;
      end
    endcase
  endfunction

  function automatic void keep_char(logic [CharW-1:0] c);
    if (held_len < Depth) begin
      held_q[held_len] = c;
      held_len++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // Closed syllable leaves one transaction per held character.
  function automatic void close_syllable();
    syl_char_t e;
    for (int unsigned i = 0; i < held_len; i++) begin
      e.ch = held_q[i];
      e.last = (i + 1 == held_len);
      e.trunc = dropped;
      pending_chars.push_back(e);
    end
    if (held_len != 0) n_syllables++;
    if (held_len != 0 && dropped) n_trunc++;
    held_len = 0;
    dropped = 1'b0;
  endfunction

  function automatic void note_used(class_e t, logic [CharW-1:0] c);
    prev_cls = t;
    prev_ch = c;
  endfunction

  function automatic void segment_char(logic [CharW-1:0] c, logic eot);
    class_e t;
    if (eot) begin
      n_eot++;
      close_syllable();
      prev_cls = CL_START;
      prev_ch = '0;
      return;
    end
    t = char_class(c, cur_mode);
    if (prev_cls == CL_START) begin
      held_len = 0;
      dropped = 1'b0;
      keep_char(c);
      case (cur_mode)
        ModeHan:    prev_cls = t;
        ModeTibRom: if (t != CL_SPEC) prev_cls = t;
        ModeTibScr: if (t == CL_PLAIN) prev_cls = t;
        default:    if (t == CL_CONS || t == CL_PLAIN) prev_cls = t;
      endcase
      return;
    end
    case (cur_mode)
      ModeHan: begin
        // each ideograph opens a new syllable
        if (t == CL_PLAIN) begin
          close_syllable();
          keep_char(c);
        end
        note_used(t, c);
      end
      ModeTibRom: begin
        if (prev_cls != CL_SPEC && t == CL_SPEC) begin
          close_syllable();
          note_used(t, c);
        end else if (t != CL_SPEC) begin
          keep_char(c);
          note_used(t, c);
        end
      end
      ModeTibScr: begin
        if (t == CL_FINAL) begin
          keep_char(c);
          close_syllable();
          note_used(t, c);
        end else if (prev_cls == CL_PLAIN && t == CL_SHAD) begin
          // shad after a letter is written out as a tsheg
          keep_char(Tsheg);
          close_syllable();
          note_used(t, c);
        end else if (t == CL_PLAIN) begin
          keep_char(c);
          note_used(t, c);
        end
      end
      default: begin
        if (t == CL_FINAL) begin
          keep_char(c);
          close_syllable();
          note_used(t, c);
        end else if (prev_cls == CL_PLAIN &&
                     (t == CL_CONS || t == CL_PLAIN || t == CL_SHAD)) begin
          if (prev_ch == LetterA && (c == LetterI || c == LetterU)) begin
            // a+i / a+u diphthong stays in one syllable
            keep_char(c);
            note_used(t, c);
          end else if (c == LetterA || c == SktRVowel || t == CL_PLAIN ||
                       t == CL_CONS) begin
            close_syllable();
            keep_char(c);
            note_used(t, c);
          end
        end else if (t == CL_PLAIN || t == CL_CONS) begin
          keep_char(c);
          note_used(t, c);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one transaction, then maybe a gap at the end of the burst
  // ---------------------------------------------------------------------
  task automatic send_char(logic [CharW-1:0] c, logic eot = 1'b0);
    push <= 1'b1;
    code_point_i <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (full);
    segment_char(c, eot);
    n_items++;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_eot();
    send_char(CharW'($urandom_range(0, 21'h1FFFFF)), 1'b1);
  endtask

  // Stop offering, wait until every expected char is back, then let the back settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_we_i <= 1'b1;
    language_mode_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    n_cfg++;
  endtask

  function automatic logic [CharW-1:0] pick_char(logic [1:0] mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return CharW'($urandom_range(0, 21'h1FFFFF));
    if (r < 10) return CharW'($urandom_range(0, 127));
    case (mode)
      ModeHan: begin
        if (r < 60) return CharW'($urandom_range(21'h4E00, 21'h9FFF));
        if (r < 85) return HanMarks[$urandom_range(0, NumHan - 1)];
        return (r < 90) ? 21'h6B : CharW'($urandom_range(21'h30, 21'h7A));
      end
      ModeTibRom: begin
        if (r < 45) return CharW'($urandom_range(21'h61, 21'h7A));
        if (r < 55) return CharW'($urandom_range(21'h41, 21'h5A));
        if (r < 60) return 21'h27;
        return (r < 80) ? 21'h20 : TibMarks[$urandom_range(0, NumTib - 1)];
      end
      ModeTibScr: begin
        if (r < 60) return CharW'($urandom_range(21'h0F40, 21'h0F6C));
        if (r < 75) return (r < 72) ? Tsheg : TshegAlt;
        if (r < 85) return (r < 82) ? Shad : ShadAlt;
        if (r < 92) return TibMarks[$urandom_range(0, NumTib - 1)];
        return (r < 95) ? 21'h6B : CharW'($urandom_range(21'h30, 21'h7A));
      end
      default: begin
        if (r < 45) return SktCons[$urandom_range(0, NumCons - 1)];
        if (r < 70) return SktVow[$urandom_range(0, NumVow - 1)];
        if (r < 80) return (r < 75) ? LetterA : ((r < 78) ? LetterI : LetterU);
        if (r < 88) begin
          case ($urandom_range(0, 2))
            0: return SktAnusM;
            1: return SktAnusN;
            default: return SktVisarg;
          endcase
        end
        return (r < 94) ? CharW'($urandom_range(21'h30, 21'h39)) : 21'h20;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_han();
    set_mode(ModeHan);
    send_char(21'h4E2D);
    send_char(21'h20);
    send_char(21'h6B);      // lowercase k counts as an ideograph here
    send_char(21'h1FFFFF);  // above the Unicode range, unlisted
    send_eot();
    send_eot();             // nothing held: no transaction out
  endtask

  task automatic test_tib_roman_overflow();
    logic [CharW-1:0] word [12] = '{21'h62, 21'h73, 21'h67, 21'h72, 21'h75, 21'h62,
                                   21'h27, 21'h6B, 21'h79, 21'h41, 21'h64, 21'h68};
    set_mode(ModeTibRom);
    foreach (word[i]) send_char(word[i]);  // 12 characters, store holds 10
    send_char(21'h20);
    send_char(21'h0);
    send_eot();
  endtask

  task automatic test_tib_script();
    set_mode(ModeTibScr);
    send_char(21'h0F40);
    send_char(Tsheg);
    send_char(21'h0F41);
    send_char(Shad);        // shad after a letter becomes a tsheg
    send_char(21'h0F42);
    send_char(TshegAlt);
    send_char(ShadAlt);
    send_eot();
  endtask

  task automatic test_sanskrit();
    set_mode(ModeSkt);
    send_char(21'h6B);
    send_char(LetterA);
    send_char(LetterI);     // a+i diphthong
    send_char(21'h74);
    send_char(LetterA);
    send_char(SktAnusM);    // final closes
    send_char(21'h72);
    send_char(SktRVowel);
    send_char(21'h35);
    send_eot();
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] modes [8] = '{ModeSkt, ModeHan, ModeTibRom, ModeTibScr,
                              ModeSkt, ModeTibRom, ModeHan, ModeTibScr};
    for (int p = 0; p < 8; p++) begin
      // sometimes switch mode mid-text, leaving the held syllable in place
      set_mode(modes[p]);
      for (int unsigned i = 0; i < count / 8; i++) begin
        if ($urandom_range(0, 19) == 0) send_eot();
        else send_char(pick_char(cur_mode));
      end
      if ($urandom_range(0, 2) != 0) send_eot();
    end
  endtask

  // Receiver holds off long enough that the command queue backs up into full.
  task automatic test_backpressure();
    set_mode(ModeTibRom);
    hold_off_cycles = 300;
    burst_left = 60;
    for (int i = 0; i < 40; i++) send_char((i % 4 == 3) ? 21'h20 : pick_char(ModeTibRom));
    send_eot();
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    syl_char_t e;
    if (rst_ni && pop && !empty) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected char out: %h", out_char_o);
        mismatches++;
      end else begin
        e = pending_chars.pop_front();
        if (out_char_o !== e.ch || syllable_last_o !== e.last ||
            syllable_truncated_o !== e.trunc) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: exp ch=%h last=%b trunc=%b  got ch=%h last=%b trunc=%b",
                     e.ch, e.last, e.trunc, out_char_o, syllable_last_o,
                     syllable_truncated_o);
          mismatches++;
        end
      end
    end
    if (pattern_left == 0) begin
      pop_pattern = $urandom_range(0, 2);
      pattern_left = $urandom_range(8, 80);
    end else begin
      pattern_left--;
    end
    if (hold_off_cycles != 0) begin
      hold_off_cycles--;
      pop <= 1'b0;
    end else begin
      case (pop_pattern)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    held_len = 0;
    prev_cls = CL_START;
    prev_ch = '0;
    dropped = 1'b0;
    cur_mode = ModeHan;
    burst_left = 5;
    hold_off_cycles = 0;
    pattern_left = 0;
    pop_pattern = 0;
    n_items = 0; n_chars = 0; n_syllables = 0; n_trunc = 0; n_eot = 0; n_cfg = 0;
    errors = 0; mismatches = 0; cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_han();
    test_tib_roman_overflow();
    test_tib_script();
    test_sanskrit();
    test_backpressure();
    test_random(320);
    drain();

    $display("%0d transactions in (%0d end-of-text), %0d chars out in %0d syllables",
             n_items, n_eot, n_chars, n_syllables);
    $display("%0d truncated syllables, %0d mode writes, %0d mismatches",
             n_trunc, n_cfg, mismatches);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sss_pkg.sv
hw/rtl/sss_front.sv
hw/rtl/sss_cmd_fifo.sv
hw/rtl/sss_back.sv
hw/rtl/script_syllable_segmenter.sv
dv/script_syllable_segmenter_tb.sv
